FILE: hw/rtl/fba_pkg.sv
package fba_pkg;

  localparam logic [32:0] MIN_BYTES   = 33'd4194304;
  localparam logic [32:0] SMALL_LIMIT = 33'd16777216;
  localparam logic [32:0] CFG_RESET   = 33'd16777216;

  localparam logic [12:0] RSV_SMALL = 13'd512;
  localparam logic [12:0] RSV_LARGE = 13'd4096;
  localparam logic [12:0] RSV_FLOOR = 13'd256;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic take_in;
    logic init_setup;
    logic sweep_step;
    logic top_scan;
    logic sum_pick;
    logic map_alloc;
    logic alloc_fail;
    logic free_read;
    logic free_write;
    logic out_load;
  } fba_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic top_hit;
    logic top_last;
    logic out_space;
  } fba_sts_t;

  // Index of the lowest clear bit; zero when the word is all ones.
  function automatic logic [4:0] first_zero(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  // Distance of a frame bound past the start of a map word, clipped to 0..32.
  function automatic logic [5:0] word_offset(input logic [20:0] bound,
                                             input logic [20:0] base);
    logic [20:0] diff;
    diff = bound - base;
    if (bound <= base) begin
      return 6'd0;
    end else if (diff >= 21'd32) begin
      return 6'd32;
    end else begin
      return 6'(diff);
    end
  endfunction

endpackage

FILE: hw/rtl/fba_ram.sv
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/fba_ctrl.sv
module fba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  fba_pkg::fba_sts_t sts,
  output fba_pkg::fba_cmd_t cmd
);
  import fba_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TOP    = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_MAP    = 4'd4;
  localparam logic [3:0] S_FREAD  = 4'd5;
  localparam logic [3:0] S_FWRITE = 4'd6;
  localparam logic [3:0] S_SETUP  = 4'd7;
  localparam logic [3:0] S_SWEEP  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          unique case (func)
            FUNC_ALLOC: state_next = S_TOP;
            FUNC_FREE:  state_next = S_FREAD;
            FUNC_INIT:  state_next = S_SETUP;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_TOP: begin
        cmd.top_scan = 1'b1;
        if (sts.top_hit) begin
          state_next = S_SUM;
        end else if (sts.top_last) begin
          cmd.alloc_fail = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_SUM: begin
        cmd.sum_pick = 1'b1;
        state_next   = S_MAP;
      end
      S_MAP: begin
        cmd.map_alloc = 1'b1;
        state_next    = S_DONE;
      end
      S_FREAD: begin
        cmd.free_read = 1'b1;
        state_next    = S_FWRITE;
      end
      S_FWRITE: begin
        cmd.free_write = 1'b1;
        state_next     = S_DONE;
      end
      S_SETUP: begin
        cmd.init_setup = 1'b1;
        state_next     = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_space) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_sweep_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && sts.sweep_last |=> state == S_DONE)
    else $error("init sweep did not hand over to result");

endmodule

FILE: hw/rtl/fba_dp.sv
module fba_dp #(
  parameter int MAP_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  fba_pkg::fba_cmd_t cmd,
  output fba_pkg::fba_sts_t sts,
  input  logic [31:0]       freed_address,
  input  logic              mem_size_bytes_we,
  input  logic [32:0]       mem_size_bytes,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [31:0]       frame_address,
  output logic [32:0]       total_bytes,
  output logic [32:0]       free_bytes
);
  import fba_pkg::*;

  localparam int WA         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SUM_WORDS  = (MAP_WORDS + 31) / 32;
  localparam int SA         = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int TOP_CHUNKS = (SUM_WORDS + 31) / 32;
  localparam int TA         = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;
  localparam logic [20:0] MAP_FRAMES = 21'(MAP_WORDS * 32);
  localparam logic [32:0] MAX_BYTES  = {MAP_FRAMES, 12'b0};

  // Registers
  logic [32:0]   cfg_size;
  logic [32:0]   managed_bytes;
  logic [16:0]   used_count;
  logic [20:0]   frames_r;
  logic [12:0]   reserved_r;
  logic [31:0]   addr_q;
  logic [WA-1:0] wcnt;
  logic [31:0]   acc;
  logic [TA-1:0] chunk;
  logic [SA-1:0] sidx_q;
  logic [WA-1:0] widx_q;
  logic [31:0]   sum_q;
  logic          res_status;
  logic [31:0]   res_addr;
  logic [31:0]   top_bits [TOP_CHUNKS];

  // RAM ports
  logic          map_we, map_re, sum_we, sum_re;
  logic [WA-1:0] map_waddr, map_raddr;
  logic [SA-1:0] sum_waddr, sum_raddr;
  logic [31:0]   map_wdata, map_rdata, sum_wdata, sum_rdata;

  fba_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // One bit per map word, set when the word is full.
  fba_ram #(.WIDTH(32), .DEPTH(SUM_WORDS)) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // Top level of the search
  logic [31:0]   top_word;
  logic [SA-1:0] top_sidx;
  assign top_word = top_bits[chunk];
  assign top_sidx = SA'({chunk, first_zero(top_word)});

  // Allocation
  logic [WA-1:0] pick_widx;
  logic [4:0]    map_bit;
  logic [31:0]   map_new;
  logic          map_full;
  logic [31:0]   sum_new_alloc;
  assign pick_widx     = WA'({sidx_q, first_zero(sum_rdata)});
  assign map_bit       = first_zero(map_rdata);
  assign map_new       = map_rdata | (32'd1 << map_bit);
  assign map_full      = &map_new;
  assign sum_new_alloc = sum_q | (32'd1 << 5'(widx_q));

  // Free
  logic [19:0]   frame_no;
  logic          f_in;
  logic [WA-1:0] f_widx;
  logic [SA-1:0] f_sidx;
  assign frame_no = addr_q[31:12];
  assign f_in     = {1'b0, frame_no} < MAP_FRAMES;
  assign f_widx   = WA'(frame_no >> 5);
  assign f_sidx   = SA'(f_widx >> 5);

  // Init sweep: one map word per cycle
  logic [20:0]   s_start;
  logic [5:0]    lo_off, hi_off;
  logic [31:0]   free_mask, sweep_word, acc_base, sweep_sum;
  logic [4:0]    gb;
  logic          sweep_full, sweep_last, sweep_sum_wr;
  logic [SA-1:0] sweep_sidx;
  assign s_start      = 21'({wcnt, 5'b0});
  assign lo_off       = word_offset({8'b0, reserved_r}, s_start);
  assign hi_off       = word_offset(frames_r, s_start);
  assign free_mask    = (32'hFFFF_FFFF << lo_off) & ~(32'hFFFF_FFFF << hi_off);
  assign sweep_word   = ~free_mask;
  assign sweep_full   = &sweep_word;
  assign gb           = 5'(wcnt);
  assign acc_base     = (gb == 5'd0) ? 32'hFFFF_FFFF : acc;
  assign sweep_sum    = acc_base & ~(32'(!sweep_full) << gb);
  assign sweep_last   = (wcnt == WA'(MAP_WORDS - 1));
  assign sweep_sum_wr = (gb == 5'd31) || sweep_last;
  assign sweep_sidx   = SA'(wcnt >> 5);

  // Init parameters from the configured size
  logic [32:0] cl_hi, cl_sz;
  logic [20:0] fr_raw, fr;
  logic [12:0] rs_base, rs_half, rs;
  always_comb begin
    cl_hi   = (cfg_size > MAX_BYTES) ? MAX_BYTES : cfg_size;
    cl_sz   = (cl_hi < MIN_BYTES) ? MIN_BYTES : cl_hi;
    fr_raw  = cl_sz[32:12];
    fr      = (fr_raw > MAP_FRAMES) ? MAP_FRAMES : fr_raw;
    rs_base = (cl_sz <= SMALL_LIMIT) ? RSV_SMALL : RSV_LARGE;
    rs_half = ({8'b0, rs_base} >= fr) ? 13'(fr >> 1) : rs_base;
    rs      = (rs_half < RSV_FLOOR) ? RSV_FLOOR : rs_half;
  end

  // RAM port steering
  always_comb begin
    map_we    = 1'b0;
    map_waddr = wcnt;
    map_wdata = sweep_word;
    map_re    = 1'b0;
    map_raddr = pick_widx;
    sum_we    = 1'b0;
    sum_waddr = sweep_sidx;
    sum_wdata = sweep_sum;
    sum_re    = 1'b0;
    sum_raddr = top_sidx;
    priority if (cmd.sweep_step) begin
      map_we = 1'b1;
      sum_we = sweep_sum_wr;
    end else if (cmd.map_alloc) begin
      map_we    = 1'b1;
      map_waddr = widx_q;
      map_wdata = map_new;
      sum_we    = map_full;
      sum_waddr = sidx_q;
      sum_wdata = sum_new_alloc;
    end else if (cmd.free_write) begin
      map_we    = f_in;
      map_waddr = f_widx;
      map_wdata = map_rdata & ~(32'd1 << frame_no[4:0]);
      sum_we    = f_in;
      sum_waddr = f_sidx;
      sum_wdata = sum_rdata & ~(32'd1 << 5'(f_widx));
    end else if (cmd.top_scan) begin
      sum_re = (top_word != 32'hFFFF_FFFF);
    end else if (cmd.sum_pick) begin
      map_re = 1'b1;
    end else if (cmd.free_read) begin
      map_re    = 1'b1;
      map_raddr = f_widx;
      sum_re    = 1'b1;
      sum_raddr = f_sidx;
    end
  end

  // Single-bit update of the top level
  logic          top_we, top_val;
  logic [SA-1:0] top_widx;
  always_comb begin
    top_we   = 1'b0;
    top_val  = 1'b1;
    top_widx = sweep_sidx;
    priority if (cmd.sweep_step) begin
      top_we  = sweep_sum_wr;
      top_val = &sweep_sum;
    end else if (cmd.map_alloc) begin
      top_we   = map_full && (&sum_new_alloc);
      top_widx = sidx_q;
    end else if (cmd.free_write) begin
      top_we   = f_in;
      top_val  = 1'b0;
      top_widx = f_sidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_setup) begin
      for (int i = 0; i < TOP_CHUNKS; i++) top_bits[i] <= 32'hFFFF_FFFF;
    end else if (top_we) begin
      top_bits[TA'(top_widx >> 5)][5'(top_widx)] <= top_val;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size      <= CFG_RESET;
      managed_bytes <= '0;
      used_count    <= '0;
      frames_r      <= '0;
      reserved_r    <= '0;
      wcnt          <= '0;
      chunk         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (mem_size_bytes_we) cfg_size <= mem_size_bytes;
      if (cmd.init_setup) begin
        managed_bytes <= cl_sz;
        frames_r      <= fr;
        reserved_r    <= rs;
        used_count    <= 17'(rs);
        wcnt          <= '0;
      end else if (cmd.sweep_step) begin
        wcnt <= sweep_last ? '0 : wcnt + 1'b1;
      end
      if (cmd.map_alloc && used_count != COUNT_MAX) used_count <= used_count + 1'b1;
      if (cmd.free_write && used_count != '0) used_count <= used_count - 1'b1;
      if (cmd.take_in) begin
        chunk <= '0;
      end else if (cmd.top_scan && top_word == 32'hFFFF_FFFF && !sts.top_last) begin
        chunk <= chunk + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [32:0] used_bytes;
  assign used_bytes = {4'b0, used_count, 12'b0};

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      addr_q     <= freed_address;
      res_status <= ST_OK;
      res_addr   <= '0;
    end
    if (cmd.alloc_fail) res_status <= ST_EXHAUSTED;
    if (cmd.map_alloc) res_addr <= 32'({widx_q, map_bit, 12'b0});
    if (cmd.sweep_step) acc <= sweep_sum;
    if (cmd.top_scan) sidx_q <= top_sidx;
    if (cmd.sum_pick) begin
      sum_q  <= sum_rdata;
      widx_q <= pick_widx;
    end
    if (cmd.out_load) begin
      status        <= res_status;
      frame_address <= res_addr;
      total_bytes   <= managed_bytes;
      free_bytes    <= (managed_bytes > used_bytes) ? managed_bytes - used_bytes : '0;
    end
  end

  assign sts.sweep_last = sweep_last;
  assign sts.top_hit    = (top_word != 32'hFFFF_FFFF);
  assign sts.top_last   = (chunk == TA'(TOP_CHUNKS - 1));
  assign sts.out_space  = !out_valid || out_ready;

  a_sum_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_pick |-> sum_rdata != 32'hFFFF_FFFF)
    else $error("summary word full although top level marked it open");

  a_map_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.map_alloc |-> map_rdata != 32'hFFFF_FFFF)
    else $error("map word full although summary marked it open");

  a_alloc_order: assert property (@(posedge clk) disable iff (rst)
    cmd.map_alloc |-> $past(cmd.sum_pick))
    else $error("map write without a preceding map read");

endmodule

FILE: hw/rtl/frame_bitmap_allocator.sv
// First-fit 4 KB frame allocator over a used-frame bitmap of MAP_WORDS*32 frames, with a
// used-frame count and the managed size. func 0 returns the lowest free frame (status 1 when
// none is left), func 1 frees the frame of freed_address, func 2 rebuilds the map from
// mem_size_bytes; every word answers with total and free bytes. The search runs over three
// levels (a flop vector of full summary words, a summary RAM with one bit per map word, the
// map RAM): an allocation scans the flop vector one group of 32*1024 frames at a time, then
// reads the summary word and then the map word before the result; a free reads and then writes
// back the map and summary words. Init rewrites the map one word per cycle. After reset the same
// sweep marks every frame used, so in_ready stays low until it ends. One word is worked on at a
// time; the result register lets the next word in while a result waits.
module frame_bitmap_allocator #(
  parameter int MAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] freed_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [31:0] frame_address,
  output logic [32:0] total_bytes,
  output logic [32:0] free_bytes,
  input  logic        mem_size_bytes_we,
  input  logic [32:0] mem_size_bytes
);
  import fba_pkg::*;

  fba_cmd_t cmd;
  fba_sts_t sts;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd)
  );

  fba_dp #(.MAP_WORDS(MAP_WORDS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .freed_address     (freed_address),
    .mem_size_bytes_we (mem_size_bytes_we),
    .mem_size_bytes    (mem_size_bytes),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .frame_address     (frame_address),
    .total_bytes       (total_bytes),
    .free_bytes        (free_bytes)
  );

endmodule

FILE: dv/frame_bitmap_allocator_test.sv
`timescale 1ns / 1ps

module frame_bitmap_allocator_test;
  import fba_pkg::*;

  localparam int         MAP_WORDS  = 1024;
  localparam longint     MAP_FRAMES = longint'(MAP_WORDS) * 32;
  localparam longint     MAP_BYTES  = MAP_FRAMES * 4096;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  typedef struct packed {
    logic        status;
    logic [31:0] frame_address;
    logic [32:0] total_bytes;
    logic [32:0] free_bytes;
  } frame_reply_t;

  typedef struct packed {
    logic         new_size;
    logic [32:0]  mem_bytes;
    logic [1:0]   op;
    logic [31:0]  addr;
    logic         typed;
    frame_reply_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_ALLOC;
  logic [31:0] freed_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [31:0] frame_address;
  logic [32:0] total_bytes;
  logic [32:0] free_bytes;
  logic        mem_size_bytes_we = 1'b0;
  logic [32:0] mem_size_bytes = CFG_RESET;

  // shadow copy of the allocator state
  logic [31:0] shadow_map [MAP_WORDS];
  logic [16:0] shadow_used;
  logic [32:0] shadow_total;
  logic [32:0] shadow_cfg;

  frame_reply_t pending_results [$];
  logic [31:0]  granted_frames [$];
  plan_row_t    plan [$];
  bit           calm = 1'b0;
  int           faults = 0;

  frame_bitmap_allocator #(
    .MAP_WORDS(MAP_WORDS)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .freed_address    (freed_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .frame_address    (frame_address),
    .total_bytes      (total_bytes),
    .free_bytes       (free_bytes),
    .mem_size_bytes_we(mem_size_bytes_we),
    .mem_size_bytes   (mem_size_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one word to the shadow state and return the reply it should get.
  function automatic frame_reply_t frame_op_result(input logic [1:0] op,
                                                   input logic [31:0] addr);
    frame_reply_t r;
    logic [19:0]  fnum;
    bit           hit;
    longint       sz;
    longint       nframes;
    longint       rsv;
    longint       used_b;
    r = '0;
    case (op)
      FUNC_ALLOC: begin
        hit = 1'b0;
        for (int w = 0; w < MAP_WORDS; w++) begin
          if (!hit && shadow_map[w] != '1) begin
            for (int b = 0; b < 32; b++) begin
              if (!hit && !shadow_map[w][b]) begin
                hit = 1'b1;
                shadow_map[w][b] = 1'b1;
                r.frame_address = 32'((longint'(w) * 32 + b) * 4096);
              end
            end
          end
        end
        if (hit) begin
          if (shadow_used != COUNT_MAX) shadow_used++;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      FUNC_FREE: begin
        fnum = addr[31:12];
        if (longint'(fnum) < MAP_FRAMES) shadow_map[fnum[19:5]][fnum[4:0]] = 1'b0;
        if (shadow_used != 0) shadow_used--;
      end
      FUNC_INIT: begin
        sz = longint'(shadow_cfg);
        if (sz > MAP_BYTES) sz = MAP_BYTES;
        if (sz < longint'(MIN_BYTES)) sz = longint'(MIN_BYTES);
        shadow_total = 33'(sz);
        nframes = sz / 4096;
        if (nframes > MAP_FRAMES) nframes = MAP_FRAMES;
        rsv = (sz <= longint'(SMALL_LIMIT)) ? longint'(RSV_SMALL) : longint'(RSV_LARGE);
        if (rsv >= nframes) rsv = nframes / 2;
        if (rsv < longint'(RSV_FLOOR)) rsv = longint'(RSV_FLOOR);
        for (int w = 0; w < MAP_WORDS; w++) shadow_map[w] = '1;
        for (longint f = rsv; f < nframes; f++) shadow_map[f / 32][f % 32] = 1'b0;
        shadow_used = (rsv > longint'(COUNT_MAX)) ? COUNT_MAX : 17'(rsv);
      end
      default: begin
      end
    endcase
    used_b = longint'(shadow_used) * 4096;
    r.total_bytes = shadow_total;
    r.free_bytes = (longint'(shadow_total) > used_b) ?
                   33'(longint'(shadow_total) - used_b) : '0;
    return r;
  endfunction

  task automatic add_row(input bit new_size, input logic [32:0] bytes,
                         input logic [1:0] op, input logic [31:0] addr,
                         input bit typed, input logic st, input logic [31:0] fa,
                         input logic [32:0] tot, input logic [32:0] fr);
    plan_row_t row;
    row.new_size  = new_size;
    row.mem_bytes = bytes;
    row.op        = op;
    row.addr      = addr;
    row.typed     = typed;
    row.want      = '{st, fa, tot, fr};
    plan.push_back(row);
  endtask

  // Present one word, hold it until taken, then log what it should return.
  task automatic push_word(input logic [1:0] op, input logic [31:0] addr,
                           input bit typed, input frame_reply_t want);
    frame_reply_t got;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= op;
    freed_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = frame_op_result(op, addr);
    if (op == FUNC_ALLOC && got.status == ST_OK) granted_frames.push_back(got.frame_address);
    if (op == FUNC_INIT) granted_frames.delete();
    pending_results.push_back(typed ? want : got);
  endtask

  // Write the size register only once the block has drained.
  task automatic set_mem_size(input logic [32:0] bytes);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    mem_size_bytes_we <= 1'b1;
    mem_size_bytes    <= bytes;
    @(posedge clk);
    mem_size_bytes_we <= 1'b0;
    shadow_cfg = bytes;
  endtask

  task automatic random_phase(input logic [32:0] bytes, input int count,
                              input int alloc_pct, input int init_pct);
    int          r;
    int          k;
    logic [31:0] a;
    set_mem_size(bytes);
    push_word(FUNC_INIT, $urandom(), 1'b0, '0);
    repeat (count) begin
      r = $urandom_range(99);
      if (r < init_pct) begin
        push_word(FUNC_INIT, $urandom(), 1'b0, '0);
      end else if (r < init_pct + 2) begin
        push_word(FUNC_NONE, $urandom(), 1'b0, '0);
      end else if (r < init_pct + 2 + alloc_pct) begin
        push_word(FUNC_ALLOC, $urandom(), 1'b0, '0);
      end else if (granted_frames.size() != 0 && $urandom_range(2) != 0) begin
        // return a frame that was handed out, at any offset inside it
        k = $urandom_range(granted_frames.size() - 1);
        a = granted_frames[k] | 32'($urandom_range(4095));
        granted_frames.delete(k);
        push_word(FUNC_FREE, a, 1'b0, '0);
      end else begin
        case ($urandom_range(2))
          0: a = $urandom();
          1: a = {5'd0, 15'($urandom_range(32767)), 12'($urandom())};
          default: a = {11'd0, 9'($urandom_range(511)), 12'($urandom())};
        endcase
        push_word(FUNC_FREE, a, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin : reply_check
    frame_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending");
        faults++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          faults++;
        end
        if (frame_address !== want.frame_address) begin
          $error("frame_address: expected %0h, actual %0h", want.frame_address,
                 frame_address);
          faults++;
        end
        if (total_bytes !== want.total_bytes) begin
          $error("total_bytes: expected %0d, actual %0d", want.total_bytes, total_bytes);
          faults++;
        end
        if (free_bytes !== want.free_bytes) begin
          $error("free_bytes: expected %0d, actual %0d", want.free_bytes, free_bytes);
          faults++;
        end
      end
    end
    out_ready <= !rst && (calm || $urandom_range(99) >= 31);
  end

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) shadow_map[w] = '1;
    shadow_used  = '0;
    shadow_total = '0;
    shadow_cfg   = CFG_RESET;

    // nothing is free before init
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_EXHAUSTED, 32'h0, 0, 0);
    add_row(0, 0, FUNC_NONE, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 0, 0);
    // count stays at zero, free bytes saturate
    add_row(0, 0, FUNC_FREE, 32'h0000_1000, 1, ST_OK, 32'h0, 0, 0);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_OK, 32'h0000_1000, 0, 0);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_EXHAUSTED, 32'h0, 0, 0);
    add_row(0, 0, FUNC_FREE, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 0, 0);
    add_row(0, 0, FUNC_FREE, 32'h07FF_FFFF, 1, ST_OK, 32'h0, 0, 0);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_OK, 32'h07FF_F000, 0, 0);
    // init from the reset size
    add_row(0, 0, FUNC_INIT, 32'h0, 1, ST_OK, 32'h0, 16777216, 14680064);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_OK, 32'h0020_0000, 16777216, 14675968);
    add_row(0, 0, FUNC_FREE, 32'h0020_0ABC, 0, 0, 0, 0, 0);
    add_row(0, 0, FUNC_FREE, 32'h0020_0000, 0, 0, 0, 0, 0);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 0, 0, 0, 0, 0);
    add_row(0, 0, FUNC_NONE, 32'h5555_AAAA, 0, 0, 0, 0, 0);
    // clamp up to the minimum and down to the map size
    add_row(1, 0, FUNC_INIT, 32'h0, 1, ST_OK, 32'h0, 4194304, 2097152);
    add_row(1, 33'h1_FFFF_FFFF, FUNC_INIT, 32'h0, 1, ST_OK, 32'h0, 134217728, 117440512);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_OK, 32'h0100_0000, 134217728, 117436416);
    // large reserve not below the frame count: halve it
    add_row(1, 16777217, FUNC_INIT, 32'h0, 1, ST_OK, 32'h0, 16777217, 8388609);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 0, 0, 0, 0, 0);
    add_row(1, 4194303, FUNC_INIT, 32'h0, 0, 0, 0, 0, 0);
    add_row(1, 134221824, FUNC_INIT, 32'h0, 0, 0, 0, 0, 0);
    // one free frame past the reserve, then exhaust
    add_row(1, 16781312, FUNC_INIT, 32'h0, 1, ST_OK, 32'h0, 16781312, 4096);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_OK, 32'h0100_0000, 16781312, 0);
    add_row(0, 0, FUNC_ALLOC, 32'h0, 1, ST_EXHAUSTED, 32'h0, 16781312, 0);
    add_row(0, 0, FUNC_FREE, 32'h0100_0000, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].new_size) set_mem_size(plan[i].mem_bytes);
      push_word(plan[i].op, plan[i].addr, plan[i].typed, plan[i].want);
    end

    // smallest map, mostly allocations: run it dry
    random_phase(33'd0, 660, 93, 0);
    calm <= 1'b1;
    random_phase(33'h1_FFFF_FFFF, 130, 45, 2);
    calm <= 1'b0;
    random_phase(33'd16777217, 130, 50, 2);
    random_phase(33'({$urandom_range(1), $urandom()}), 130, 50, 2);
    random_phase(SMALL_LIMIT, 130, 50, 2);
    random_phase(MIN_BYTES + 33'($urandom_range(12 * 1048576)), 130, 60, 2);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (faults == 0) begin
      $display("[frame_bitmap_allocator] OK");
    end else begin
      $display("[frame_bitmap_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[frame_bitmap_allocator] ERROR");
    $finish;
  end

endmodule
